>>> hdl/ffa_pkg.sv
package ffa_pkg;

    localparam int HEAP_UNITS_DEF = 4096;
    localparam int SLAB_UNITS_DEF = 1024;
    localparam int UNIT_BYTES_DEF = 16;

    localparam int BYTES_W = 16;
    localparam int ADDR_W  = 12;
    localparam int USED_W  = 17;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] STAT_DONE      = 2'd0;
    localparam logic [1:0] STAT_NO_SPACE  = 2'd1;
    localparam logic [1:0] STAT_ZERO_SIZE = 2'd2;

    typedef struct packed {
        logic               opcode;
        logic [BYTES_W-1:0] request_bytes;
        logic [ADDR_W-1:0]  block_address;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] granted_address;
        logic [1:0]        status;
        logic [USED_W-1:0] bytes_in_use;
    } rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DISPATCH, ST_DIV2, ST_MAKE, ST_ASTART, ST_ARESUME, ST_AGETP,
        ST_AREAD, ST_ACHK, ST_AADV, ST_UNLINK, ST_SPLIT1, ST_SPLIT2, ST_SLAB,
        ST_FSIZE, ST_ISTART, ST_ISTEP, ST_IPLACED, ST_IRIGHT, ST_ILEFT,
        ST_FAIL, ST_DONE0, ST_ZERO, ST_RESP
    } state_t;

    typedef enum logic [4:0] {
        CMD_NONE, CMD_CAPTURE, CMD_DIV1, CMD_DIV2, CMD_MAKE, CMD_A_START,
        CMD_A_RESUME, CMD_A_GETP, CMD_A_READ, CMD_A_LATCH, CMD_A_ADV,
        CMD_A_UNLINK, CMD_A_SPLIT1, CMD_A_SPLIT2, CMD_SLAB, CMD_F_READ,
        CMD_F_SIZE, CMD_I_START, CMD_I_STEP, CMD_I_PLACED, CMD_I_RIGHT,
        CMD_I_LEFT, CMD_FAIL, CMD_DONE0, CMD_ZERO, CMD_LOAD
    } dp_cmd_t;

    typedef struct packed {
        logic is_free;
        logic req_zero;
        logic list_made;
        logic free_ok;
        logic size_ok;
        logic a_limit;
        logic fit;
        logic exact;
        logic p_is_rover;
        logic slab_ok;
        logic place;
        logic i_limit;
        logic out_free;
    } dp_stat_t;

endpackage

>>> hdl/ffa_ctrl.sv
module ffa_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ffa_pkg::dp_stat_t  stat,
    output ffa_pkg::dp_cmd_t   cmd
);
    import ffa_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd        = CMD_CAPTURE;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (stat.is_free) begin
                    if (stat.free_ok) begin
                        cmd        = CMD_F_READ;
                        state_next = ST_FSIZE;
                    end else begin
                        state_next = ST_DONE0;
                    end
                end else if (stat.req_zero) begin
                    state_next = ST_ZERO;
                end else begin
                    cmd        = CMD_DIV1;
                    state_next = ST_DIV2;
                end
            end
            ST_DIV2: begin
                cmd        = CMD_DIV2;
                state_next = stat.list_made ? ST_ASTART : ST_MAKE;
            end
            ST_MAKE: begin
                cmd        = CMD_MAKE;
                state_next = ST_ASTART;
            end
            ST_ASTART: begin
                cmd        = CMD_A_START;
                state_next = ST_AGETP;
            end
            ST_ARESUME: begin
                cmd        = CMD_A_RESUME;
                state_next = ST_AGETP;
            end
            ST_AGETP: begin
                cmd        = CMD_A_GETP;
                state_next = ST_AREAD;
            end
            ST_AREAD: begin
                if (stat.a_limit) begin
                    state_next = ST_FAIL;
                end else begin
                    cmd        = CMD_A_READ;
                    state_next = ST_ACHK;
                end
            end
            ST_ACHK: begin
                cmd = CMD_A_LATCH;
                if (stat.fit) begin
                    state_next = stat.exact ? ST_UNLINK : ST_SPLIT1;
                end else if (stat.p_is_rover) begin
                    state_next = ST_SLAB;
                end else begin
                    state_next = ST_AADV;
                end
            end
            ST_AADV: begin
                cmd        = CMD_A_ADV;
                state_next = ST_AREAD;
            end
            ST_UNLINK: begin
                cmd        = CMD_A_UNLINK;
                state_next = ST_RESP;
            end
            ST_SPLIT1: begin
                cmd        = CMD_A_SPLIT1;
                state_next = ST_SPLIT2;
            end
            ST_SPLIT2: begin
                cmd        = CMD_A_SPLIT2;
                state_next = ST_RESP;
            end
            ST_SLAB: begin
                if (stat.slab_ok) begin
                    cmd        = CMD_SLAB;
                    state_next = ST_ISTART;
                end else begin
                    state_next = ST_FAIL;
                end
            end
            ST_FSIZE: begin
                cmd        = CMD_F_SIZE;
                state_next = stat.size_ok ? ST_ISTART : ST_DONE0;
            end
            ST_ISTART: begin
                cmd        = CMD_I_START;
                state_next = ST_ISTEP;
            end
            ST_ISTEP: begin
                cmd = CMD_I_STEP;
                if (stat.place) begin
                    state_next = ST_IPLACED;
                end else if (stat.i_limit) begin
                    state_next = stat.is_free ? ST_DONE0 : ST_FAIL;
                end
            end
            ST_IPLACED: begin
                cmd        = CMD_I_PLACED;
                state_next = ST_IRIGHT;
            end
            ST_IRIGHT: begin
                cmd        = CMD_I_RIGHT;
                state_next = ST_ILEFT;
            end
            ST_ILEFT: begin
                cmd        = CMD_I_LEFT;
                state_next = stat.is_free ? ST_DONE0 : ST_ARESUME;
            end
            ST_FAIL: begin
                cmd        = CMD_FAIL;
                state_next = ST_RESP;
            end
            ST_DONE0: begin
                cmd        = CMD_DONE0;
                state_next = ST_RESP;
            end
            ST_ZERO: begin
                cmd        = CMD_ZERO;
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (stat.out_free) begin
                    cmd        = CMD_LOAD;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/ffa_dp.sv
module ffa_dp #(
    parameter int HEAP_UNITS = ffa_pkg::HEAP_UNITS_DEF,
    parameter int SLAB_UNITS = ffa_pkg::SLAB_UNITS_DEF,
    parameter int UNIT_BYTES = ffa_pkg::UNIT_BYTES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  ffa_pkg::dp_cmd_t  cmd,
    input  ffa_pkg::req_t     s_payload,
    output ffa_pkg::dp_stat_t stat,
    output logic              m_valid,
    input  logic              m_ready,
    output ffa_pkg::rsp_t     m_payload
);
    import ffa_pkg::*;

    localparam int IW    = $clog2(HEAP_UNITS + 1);
    localparam int LIMIT = 3 * (HEAP_UNITS + 2);
    localparam int SW    = $clog2(LIMIT + 2);
    localparam int DS    = 24;
    localparam int RM    = (1 << DS) / UNIT_BYTES;
    localparam int MW    = $clog2(RM + 1);
    localparam int XW    = BYTES_W + 1;
    localparam int PW    = XW + MW;
    localparam int NW    = $clog2((65535 + UNIT_BYTES - 1) / UNIT_BYTES + 3);
    localparam int UBW   = $clog2(UNIT_BYTES + 1);
    localparam int SLW   = $clog2(SLAB_UNITS + 1);
    localparam int NUW   = (NW > SLW) ? NW : SLW;
    localparam int CW    = ((NUW > IW) ? NUW : IW) + 1;
    localparam int FW    = ((IW > ADDR_W) ? IW : ADDR_W) + 1;
    localparam int GXW   = ((IW + 1) > ADDR_W) ? (IW + 1) : ADDR_W;
    localparam int NBW   = NW + UBW;
    localparam int UAW   = ((NBW > USED_W) ? NBW : USED_W) + 1;
    localparam int BBW   = IW + UBW;
    localparam int USW   = (BBW > USED_W) ? BBW : USED_W;
    localparam logic [IW-1:0] SENT = IW'(HEAP_UNITS);
    localparam logic [USED_W-1:0] USED_MAX = '1;

    logic [IW-1:0] link_mem [0:HEAP_UNITS];
    logic [IW-1:0] size_mem [0:HEAP_UNITS];

    logic [IW-1:0] link_q, size_q;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          link_we, size_we;
    logic [IW-1:0] link_wa, link_wd, size_wa, size_wd;

    logic               op_reg;
    logic [BYTES_W-1:0] nbytes_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [PW-1:0]      prod_reg;
    logic [NW-1:0]      need_reg;
    logic [IW-1:0]      rover_reg, prev_reg, p_reg, bp_reg, plink_reg, blink_reg;
    logic [IW-1:0]      psz_reg, bsz_reg, brk_reg;
    logic [IW:0]        sp_reg;
    logic               list_made_reg, count_reg, mr_reg, ml_reg;
    logic [USED_W-1:0]  used_reg;
    logic [SW-1:0]      a_steps_reg, i_steps_reg;
    logic [ADDR_W-1:0]  res_granted_reg;
    logic [1:0]         res_status_reg;
    logic               m_valid_reg;
    rsp_t               m_payload_reg;

    logic [XW-1:0]     x_val;
    logic [NW-1:0]     q_est;
    logic [XW:0]       q_ub, r_val;
    logic [NW-1:0]     need_val;
    logic [NUW-1:0]    nu_val;
    logic [ADDR_W-1:0] hdr_val;
    logic [IW:0]       kb, kp, kn;
    logic [IW-1:0]     merged_r, merged_l;
    logic [UAW-1:0]    used_add;
    logic [USED_W-1:0] used_grant;
    logic [USW-1:0]    free_bytes;
    logic [USED_W-1:0] used_free;

    function automatic logic [IW:0] rank(input logic [IW-1:0] i);
        return (i == SENT) ? '0 : ({1'b0, i} + (IW+1)'(1));
    endfunction

    function automatic logic [IW-1:0] sat_size(input logic [IW:0] v);
        return (v > (IW+1)'(HEAP_UNITS)) ? SENT : v[IW-1:0];
    endfunction

    assign x_val    = XW'(nbytes_reg) + XW'(UNIT_BYTES - 1);
    assign q_est    = NW'(prod_reg >> DS);
    assign q_ub     = (XW+1)'(q_est) * (XW+1)'(UNIT_BYTES);
    assign r_val    = (XW+1)'(x_val) - q_ub;
    assign need_val = q_est + NW'(r_val >= (XW+1)'(UNIT_BYTES)) + NW'(1);
    assign nu_val   = (NUW'(need_reg) < NUW'(SLAB_UNITS)) ? NUW'(SLAB_UNITS) : NUW'(need_reg);
    assign hdr_val  = addr_reg - ADDR_W'(1);

    assign kb = rank(bp_reg);
    assign kp = rank(p_reg);
    assign kn = rank(link_q);

    assign merged_r = sat_size({1'b0, bsz_reg} + {1'b0, size_q});
    assign merged_l = sat_size({1'b0, psz_reg} + {1'b0, bsz_reg});

    assign used_add   = UAW'(used_reg) + UAW'(NBW'(need_reg) * NBW'(UNIT_BYTES));
    assign used_grant = (used_add > UAW'(USED_MAX)) ? USED_MAX : used_add[USED_W-1:0];
    assign free_bytes = USW'(BBW'(bsz_reg) * BBW'(UNIT_BYTES));
    assign used_free  = (USW'(used_reg) > free_bytes) ?
                        USED_W'(USW'(used_reg) - free_bytes) : '0;

    always_comb begin
        stat.is_free    = (op_reg == OP_FREE);
        stat.req_zero   = (nbytes_reg == '0);
        stat.list_made  = list_made_reg;
        stat.free_ok    = (addr_reg != '0) && list_made_reg &&
                          (FW'(hdr_val) < FW'(brk_reg));
        stat.size_ok    = (size_q != '0) && (size_q <= (brk_reg - bp_reg));
        stat.a_limit    = (a_steps_reg > SW'(LIMIT));
        stat.fit        = (CW'(size_q) >= CW'(need_reg));
        stat.exact      = (CW'(size_q) == CW'(need_reg));
        stat.p_is_rover = (p_reg == rover_reg);
        stat.slab_ok    = (CW'(brk_reg) <= CW'(HEAP_UNITS)) &&
                          (CW'(nu_val) <= (CW'(HEAP_UNITS) - CW'(brk_reg)));
        stat.place      = ((kb > kp) && (kb < kn)) || ((kp >= kn) && ((kb > kp) || (kb < kn)));
        stat.i_limit    = (i_steps_reg >= SW'(LIMIT));
        stat.out_free   = !m_valid_reg || m_ready;
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = rover_reg;
        link_we = 1'b0;
        link_wa = p_reg;
        link_wd = bp_reg;
        size_we = 1'b0;
        size_wa = p_reg;
        size_wd = merged_l;
        case (cmd) inside
            CMD_A_START, CMD_A_RESUME, CMD_I_START: begin
                rd_en = 1'b1;
            end
            CMD_A_READ: begin
                rd_en   = 1'b1;
                rd_addr = p_reg;
            end
            CMD_F_READ: begin
                rd_en   = 1'b1;
                rd_addr = IW'(hdr_val);
            end
            CMD_I_STEP: begin
                rd_en   = !stat.place;
                rd_addr = link_q;
            end
            CMD_I_PLACED: begin
                rd_en   = 1'b1;
                rd_addr = plink_reg;
            end
            CMD_MAKE: begin
                link_we = 1'b1;
                link_wa = SENT;
                link_wd = SENT;
                size_we = 1'b1;
                size_wa = SENT;
                size_wd = '0;
            end
            CMD_A_UNLINK: begin
                link_we = 1'b1;
                link_wa = prev_reg;
                link_wd = plink_reg;
            end
            CMD_A_SPLIT1: begin
                size_we = 1'b1;
                size_wd = psz_reg - IW'(need_reg);
            end
            CMD_A_SPLIT2: begin
                size_we = (sp_reg <= {1'b0, SENT});
                size_wa = sp_reg[IW-1:0];
                size_wd = IW'(need_reg);
            end
            CMD_SLAB: begin
                size_we = 1'b1;
                size_wa = brk_reg;
                size_wd = IW'(nu_val);
            end
            CMD_I_RIGHT: begin
                link_we = 1'b1;
                link_wa = bp_reg;
                link_wd = mr_reg ? link_q : plink_reg;
                size_we = mr_reg;
                size_wa = bp_reg;
                size_wd = merged_r;
            end
            CMD_I_LEFT: begin
                link_we = 1'b1;
                link_wd = ml_reg ? blink_reg : bp_reg;
                size_we = ml_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            link_q <= link_mem[rd_addr];
            size_q <= size_mem[rd_addr];
        end
        if (link_we) begin
            link_mem[link_wa] <= link_wd;
        end
        if (size_we) begin
            size_mem[size_wa] <= size_wd;
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd)
            CMD_CAPTURE: begin
                op_reg     <= s_payload.opcode;
                nbytes_reg <= s_payload.request_bytes;
                addr_reg   <= s_payload.block_address;
            end
            CMD_DIV1: prod_reg <= PW'(x_val) * PW'(RM);
            CMD_DIV2: need_reg <= need_val;
            CMD_A_START: begin
                a_steps_reg <= '0;
                prev_reg    <= rover_reg;
            end
            CMD_A_RESUME: prev_reg <= rover_reg;
            CMD_A_GETP: p_reg <= link_q;
            CMD_A_READ: a_steps_reg <= a_steps_reg + SW'(1);
            CMD_A_LATCH: begin
                psz_reg   <= size_q;
                plink_reg <= link_q;
            end
            CMD_A_ADV: begin
                prev_reg <= p_reg;
                p_reg    <= plink_reg;
            end
            CMD_A_UNLINK: begin
                res_granted_reg <= ADDR_W'(GXW'(p_reg) + GXW'(1));
                res_status_reg  <= STAT_DONE;
            end
            CMD_A_SPLIT1: sp_reg <= {1'b0, p_reg} + {1'b0, psz_reg - IW'(need_reg)};
            CMD_A_SPLIT2: begin
                res_granted_reg <= ADDR_W'(GXW'(sp_reg) + GXW'(1));
                res_status_reg  <= STAT_DONE;
            end
            CMD_SLAB: begin
                bp_reg    <= brk_reg;
                bsz_reg   <= IW'(nu_val);
                count_reg <= 1'b0;
            end
            CMD_F_READ: begin
                bp_reg    <= IW'(hdr_val);
                count_reg <= 1'b1;
            end
            CMD_F_SIZE: bsz_reg <= size_q;
            CMD_I_START: begin
                p_reg       <= rover_reg;
                i_steps_reg <= '0;
            end
            CMD_I_STEP: begin
                plink_reg <= link_q;
                psz_reg   <= size_q;
                if (!stat.place) begin
                    p_reg       <= link_q;
                    i_steps_reg <= i_steps_reg + SW'(1);
                end
            end
            CMD_I_PLACED: begin
                mr_reg <= (plink_reg != SENT) &&
                          (({1'b0, bp_reg} + {1'b0, bsz_reg}) == {1'b0, plink_reg});
                ml_reg <= (p_reg != SENT) &&
                          (({1'b0, p_reg} + {1'b0, psz_reg}) == {1'b0, bp_reg});
            end
            CMD_I_RIGHT: begin
                blink_reg <= mr_reg ? link_q : plink_reg;
                if (mr_reg) begin
                    bsz_reg <= merged_r;
                end
            end
            CMD_FAIL: begin
                res_granted_reg <= '0;
                res_status_reg  <= STAT_NO_SPACE;
            end
            CMD_DONE0: begin
                res_granted_reg <= '0;
                res_status_reg  <= STAT_DONE;
            end
            CMD_ZERO: begin
                res_granted_reg <= '0;
                res_status_reg  <= STAT_ZERO_SIZE;
            end
            CMD_LOAD: begin
                m_payload_reg.granted_address <= res_granted_reg;
                m_payload_reg.status          <= res_status_reg;
                m_payload_reg.bytes_in_use    <= used_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rover_reg     <= SENT;
            list_made_reg <= 1'b0;
            brk_reg       <= '0;
            used_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            case (cmd) inside
                CMD_MAKE: begin
                    rover_reg     <= SENT;
                    list_made_reg <= 1'b1;
                end
                CMD_A_UNLINK, CMD_A_SPLIT2: begin
                    rover_reg <= prev_reg;
                    used_reg  <= used_grant;
                end
                CMD_SLAB: brk_reg <= brk_reg + IW'(nu_val);
                CMD_I_PLACED: begin
                    if (count_reg) begin
                        used_reg <= used_free;
                    end
                end
                CMD_I_LEFT: rover_reg <= p_reg;
                default: begin
                end
            endcase
            if (cmd == CMD_LOAD) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

>>> hdl/first_fit_free_list_allocator_core.sv
// Allocate walks the free list from the rover to the first block that fits: an exact fit
// is unlinked, a larger one split and its tail granted. The first allocate makes the list;
// if the walk gets back to the rover, a slab is added and linked in and the walk resumes.
// Free links the block back in address order, merging neighbours; an ignored free or a
// zero-size request skips the walk. The single-port read of the link and size memories
// paces the walk. One item is processed at a time; the next is accepted from the cycle
// its result appears. Reset (synchronous, active low) empties the heap; memories are not cleared.
module first_fit_free_list_allocator_core #(
    parameter int HEAP_UNITS = ffa_pkg::HEAP_UNITS_DEF,
    parameter int SLAB_UNITS = ffa_pkg::SLAB_UNITS_DEF,
    parameter int UNIT_BYTES = ffa_pkg::UNIT_BYTES_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  ffa_pkg::req_t s_payload,
    output logic          m_valid,
    input  logic          m_ready,
    output ffa_pkg::rsp_t m_payload
);
    import ffa_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    ffa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ffa_dp #(
        .HEAP_UNITS (HEAP_UNITS),
        .SLAB_UNITS (SLAB_UNITS),
        .UNIT_BYTES (UNIT_BYTES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_payload (s_payload),
        .stat      (stat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("new item accepted while one is in progress");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_payload.status == STAT_DONE || m_payload.status == STAT_NO_SPACE ||
                     m_payload.status == STAT_ZERO_SIZE))
        else $error("undefined status code");

    a_fail_no_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.status != STAT_DONE) |-> (m_payload.granted_address == '0))
        else $error("failed request carries an address");

endmodule

>>> tb/ffa_checker.sv
module ffa_checker (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic          s_ready,
    input  ffa_pkg::req_t s_payload,
    input  logic          m_valid,
    input  logic          m_ready,
    input  ffa_pkg::rsp_t m_payload,
    output int            fail_count,
    output int            pending
);
    import ffa_pkg::*;

    localparam int unsigned HEAP  = HEAP_UNITS_DEF;
    localparam int unsigned SLAB  = SLAB_UNITS_DEF;
    localparam int unsigned UBYTE = UNIT_BYTES_DEF;
    localparam int unsigned SENT  = HEAP;
    localparam int unsigned BYTES_CAP = 131071;
    localparam int unsigned WALK_CAP  = 3 * (HEAP + 2);

    int unsigned link_mem [0:HEAP];
    int unsigned size_mem [0:HEAP];
    int unsigned rover;
    bit          list_ready;
    int unsigned brk;
    int unsigned in_use;
    rsp_t        grant_q [$];

    function automatic int unsigned rd_link(int unsigned i);
        return (i <= SENT) ? link_mem[i] : 0;
    endfunction

    function automatic int unsigned rd_size(int unsigned i);
        return (i <= SENT) ? size_mem[i] : 0;
    endfunction

    function automatic void wr_link(int unsigned i, int unsigned v);
        if (i <= SENT) link_mem[i] = v;
    endfunction

    function automatic void wr_size(int unsigned i, int unsigned v);
        if (i <= SENT) size_mem[i] = (v > HEAP) ? HEAP : v;
    endfunction

    // The sentinel ranks below every heap unit.
    function automatic int unsigned addr_rank(int unsigned i);
        return (i == SENT) ? 0 : i + 1;
    endfunction

    function automatic bit link_in(int unsigned bp, bit count);
        int unsigned p, steps, kb, kp, kn, nxt, bsz, b;
        p = rover;
        steps = 0;
        kb = addr_rank(bp);
        forever begin
            kp = addr_rank(p);
            kn = addr_rank(rd_link(p));
            if (kb > kp && kb < kn) break;
            if (kp >= kn && (kb > kp || kb < kn)) break;
            p = rd_link(p);
            steps++;
            if (steps > WALK_CAP) return 0;
        end
        if (count) begin
            b = rd_size(bp) * UBYTE;
            in_use = (in_use > b) ? in_use - b : 0;
        end
        nxt = rd_link(p);
        bsz = rd_size(bp);
        if (nxt != SENT && bp + bsz == nxt) begin
            wr_size(bp, bsz + rd_size(nxt));
            wr_link(bp, rd_link(nxt));
        end else begin
            wr_link(bp, nxt);
        end
        if (p != SENT && p + rd_size(p) == bp) begin
            wr_size(p, rd_size(p) + rd_size(bp));
            wr_link(p, rd_link(bp));
        end else begin
            wr_link(p, bp);
        end
        rover = p;
        return 1;
    endfunction

    function automatic bit grow_heap(int unsigned need);
        int unsigned nu, up;
        nu = (need < SLAB) ? SLAB : need;
        if (brk > HEAP || nu > HEAP - brk) return 0;
        up = brk;
        wr_size(up, nu);
        brk += nu;
        return link_in(up, 0);
    endfunction

    function automatic rsp_t serve(req_t r);
        rsp_t        e;
        int unsigned need, prev, p, psz, steps, hdr, sz;
        e.granted_address = '0;
        e.status = STAT_DONE;
        if (r.opcode == OP_ALLOC) begin
            if (r.request_bytes == 0) begin
                e.status = STAT_ZERO_SIZE;
            end else begin
                need = (int'(r.request_bytes) + UBYTE - 1) / UBYTE + 1;
                if (!list_ready) begin
                    wr_link(SENT, SENT);
                    wr_size(SENT, 0);
                    rover = SENT;
                    list_ready = 1;
                end
                prev = rover;
                p = rd_link(prev);
                steps = 0;
                e.status = STAT_NO_SPACE;
                while (steps <= WALK_CAP) begin
                    steps++;
                    psz = rd_size(p);
                    if (psz >= need) begin
                        if (psz == need) begin
                            wr_link(prev, rd_link(p));
                        end else begin
                            wr_size(p, psz - need);
                            p += psz - need;
                            wr_size(p, need);
                        end
                        rover = prev;
                        in_use += need * UBYTE;
                        if (in_use > BYTES_CAP) in_use = BYTES_CAP;
                        e.granted_address = ADDR_W'(p + 1);
                        e.status = STAT_DONE;
                        break;
                    end
                    if (p == rover) begin
                        if (!grow_heap(need)) break;
                        p = rover;
                    end
                    prev = p;
                    p = rd_link(p);
                end
            end
        end else if (r.block_address != 0 && list_ready) begin
            hdr = int'(r.block_address) - 1;
            if (hdr < brk) begin
                sz = rd_size(hdr);
                if (sz != 0 && sz <= brk - hdr) void'(link_in(hdr, 1));
            end
        end
        e.bytes_in_use = USED_W'(in_use);
        return e;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        for (int i = 0; i <= int'(HEAP); i++) begin
            link_mem[i] = 0;
            size_mem[i] = 0;
        end
    end

    assign pending = grant_q.size();

    always @(posedge aclk) begin
        rsp_t want;
        if (!aresetn) begin
            rover = SENT;
            list_ready = 0;
            brk = 0;
            in_use = 0;
            grant_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (grant_q.size() == 0) begin
                    $display("mismatch at %0t: result item with none expected", $realtime);
                    fail_count++;
                end else begin
                    want = grant_q.pop_front();
                    if (m_payload.granted_address !== want.granted_address)
                        report_mismatch("granted_address", m_payload.granted_address,
                                        want.granted_address);
                    if (m_payload.status !== want.status)
                        report_mismatch("status", m_payload.status, want.status);
                    if (m_payload.bytes_in_use !== want.bytes_in_use)
                        report_mismatch("bytes_in_use", m_payload.bytes_in_use,
                                        want.bytes_in_use);
                end
            end
            if (s_valid && s_ready) grant_q.push_back(serve(s_payload));
        end
    end

endmodule

>>> tb/tb_first_fit_free_list_allocator_core.sv
module tb_first_fit_free_list_allocator_core;
    import ffa_pkg::*;

    localparam int TOTAL     = 1800;
    localparam int MAX_CYCLES = TOTAL * 4 * (9 * (HEAP_UNITS_DEF + 2) + 100);

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    req_t s_payload;
    logic m_valid;
    logic m_ready;
    rsp_t m_payload;
    int   fail_count;
    int   pending;
    int   sent;
    int   n_alloc;
    int   n_free;
    int   cycles;
    int   live_q [$];
    int   granted_q [$];

    first_fit_free_list_allocator_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    ffa_checker u_chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_payload  (s_payload),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_payload  (m_payload),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial aclk = 0;
    always begin
        #6 aclk = 1;
        #6 aclk = 0;
    end

    initial begin
        aresetn = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1;
    end

    function automatic int idle_phase();
        return (sent * 4) / TOTAL;
    endfunction

    function automatic req_t alloc_req(int nbytes);
        req_t r;
        r.opcode = OP_ALLOC;
        r.request_bytes = BYTES_W'(nbytes);
        r.block_address = ADDR_W'($urandom);
        return r;
    endfunction

    function automatic req_t free_req(int addr);
        req_t r;
        r.opcode = OP_FREE;
        r.request_bytes = BYTES_W'($urandom);
        r.block_address = ADDR_W'(addr);
        return r;
    endfunction

    // Only addresses whose header has been written are ever freed once the list exists.
    function automatic req_t free_live();
        int k, a;
        if (live_q.size() == 0) return free_req(0);
        k = $urandom_range(live_q.size() - 1);
        a = live_q[k];
        live_q.delete(k);
        return free_req(a);
    endfunction

    function automatic req_t free_stale();
        if (granted_q.size() == 0) return free_req(0);
        return free_req(granted_q[$urandom_range(granted_q.size() - 1)]);
    endfunction

    function automatic int random_bytes();
        int r;
        r = $urandom_range(99);
        if (r < 70) return $urandom_range(1, 200);
        if (r < 90) return $urandom_range(201, 4000);
        if (r < 98) return $urandom_range(4001, 20000);
        return $urandom_range(20001, 65535);
    endfunction

    function automatic req_t next_req();
        int r, alloc_pct;
        case (sent)
            0:  return free_req(0);
            1:  return free_req(12'hFFF);
            2:  return free_req(12'h555);
            3:  return alloc_req(0);
            4:  return alloc_req(16'hFFFF);
            5:  return alloc_req(1);
            6:  return alloc_req(16);
            7:  return alloc_req(17);
            8:  return alloc_req(16368);
            9:  return alloc_req(48000);
            10: return free_req(1);
            11: return free_live();
            12: return free_live();
            13: return free_stale();
            14: return free_req(0);
            15: return alloc_req(16'hAAAA);
            16: return alloc_req(16'h5555);
            17, 18, 19, 20, 21, 22: return free_live();
            23: return alloc_req(16'hFFFF);
            24: return alloc_req(8);
            default: begin
                alloc_pct = 50 + 15 * ((sent / 150) % 3);
                r = $urandom_range(99);
                if (r < alloc_pct) return alloc_req(random_bytes());
                r = $urandom_range(99);
                if (r < 70) return free_live();
                if (r < 88) return free_stale();
                if (r < 94 && granted_q.size() != 0) return free_req(1);
                return free_req(0);
            end
        endcase
    endfunction

    always @(posedge aclk) begin
        req_t r;
        int ph;
        if (!aresetn) begin
            s_valid <= 0;
            s_payload <= '0;
            sent <= 0;
            n_alloc <= 0;
            n_free <= 0;
        end else if (!s_valid || s_ready) begin
            ph = idle_phase();
            if (sent < TOTAL && !((ph == 1 && $urandom_range(99) < 51) ||
                                  (ph == 3 && $urandom_range(99) < 32))) begin
                r = next_req();
                s_valid <= 1;
                s_payload <= r;
                sent <= sent + 1;
                if (r.opcode == OP_ALLOC) n_alloc <= n_alloc + 1;
                else n_free <= n_free + 1;
            end else begin
                s_valid <= 0;
            end
        end
    end

    always @(posedge aclk) begin
        int ph;
        ph = idle_phase();
        if (!aresetn) m_ready <= 0;
        else if (ph == 2) m_ready <= ($urandom_range(99) >= 51);
        else if (ph == 3) m_ready <= ($urandom_range(99) >= 32);
        else m_ready <= 1;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready && m_payload.status == STAT_DONE &&
            m_payload.granted_address != 0) begin
            live_q.push_back(m_payload.granted_address);
            granted_q.push_back(m_payload.granted_address);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            cycles <= 0;
        end else begin
            cycles <= cycles + 1;
            if (cycles > MAX_CYCLES) begin
                $display("Timed out with %0d results outstanding.", pending);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        wait (aresetn === 1'b1);
        wait (sent == TOTAL && !s_valid && pending == 0);
        repeat (200) @(posedge aclk);
        $display("Sent %0d requests: %0d allocates and %0d frees, %0d blocks granted,",
                 sent, n_alloc, n_free, granted_q.size());
        $display("across phases with no idling, sender gaps, receiver stalls and both.");
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> first_fit_free_list_allocator_core.f
hdl/ffa_pkg.sv
hdl/ffa_ctrl.sv
hdl/ffa_dp.sv
hdl/first_fit_free_list_allocator_core.sv
tb/ffa_checker.sv
tb/tb_first_fit_free_list_allocator_core.sv
